### sv/ofd_pkg.sv
// Package for the offset frame deframer: frame position codes, result type,
// register map constants. No dependencies.

package ofd_pkg;

  // Register map (word-aligned, one register)
  localparam int unsigned PaddrW       = 3;
  localparam int unsigned RegIdxBit    = 2;
  localparam logic [7:0]  MarkerReset  = 8'h24;

  // Widths of the item fields
  localparam int unsigned ByteW    = 8;
  localparam int unsigned PayloadW = 32;
  localparam int unsigned SumW     = 11;  // five bytes of at most 255
  localparam int unsigned CheckW   = 16;
  localparam int unsigned TdataOutW = ByteW + PayloadW;

  // Frame position: hunting, then the seven frame bytes in order
  typedef enum logic [2:0] {
    ST_HUNT   = 3'd0,
    ST_CMD    = 3'd1,
    ST_PL0    = 3'd2,
    ST_PL1    = 3'd3,
    ST_PL2    = 3'd4,
    ST_PL3    = 3'd5,
    ST_CHK_HI = 3'd6,
    ST_CHK_LO = 3'd7
  } frame_state_e;

  // Result of a frame that passed its check
  typedef struct packed {
    logic [PayloadW-1:0] payload;
    logic [ByteW-1:0]    command;
  } frame_result_t;

  // Collector status seen by the top level
  typedef struct packed {
    frame_state_e state;
    logic         emit;
  } collect_status_t;

endpackage

### sv/ofd_cfg.sv
// APB-style register port for the offset frame deframer.
// Holds the start marker register. Depends on ofd_pkg.

module ofd_cfg
  import ofd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [ByteW-1:0]  marker_o
);

  logic             hit;
  logic [ByteW-1:0] marker_d, marker_q;

  assign pready = 1'b1;
  assign hit    = (paddr[RegIdxBit] == 1'b0);

  // Write the marker on a completed write transfer
  always_comb begin
    marker_d = marker_q;
    if (psel && penable && pwrite && pready && hit) begin
      marker_d = pwdata[ByteW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= MarkerReset;
    end else begin
      marker_q <= marker_d;
    end
  end

  // Read back
  assign prdata   = hit ? {{(32-ByteW){1'b0}}, marker_q} : 32'd0;
  assign marker_o = marker_q;

endmodule

### sv/ofd_collect.sv
// Frame collector: hunts for the marker, decodes and gathers frame bytes,
// checks the additive checksum. Depends on ofd_pkg.

module ofd_collect
  import ofd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic [ByteW-1:0] marker_i,
  output frame_result_t   result_o,
  output collect_status_t status_o
);

  frame_state_e        state_d, state_q;
  logic [ByteW-1:0]    command_d, command_q;
  logic [PayloadW-1:0] payload_d, payload_q;
  logic [SumW-1:0]     sum_d, sum_q;
  logic [ByteW-1:0]    chk_hi_d, chk_hi_q;
  logic [ByteW-1:0]    dec;
  logic [CheckW-1:0]   check;
  logic                emit;

  assign dec   = rx_byte_i - 8'd1;
  assign check = {chk_hi_q, dec};

  // Next state, hold updates and result strobe
  always_comb begin
    state_d   = state_q;
    command_d = command_q;
    payload_d = payload_q;
    sum_d     = sum_q;
    chk_hi_d  = chk_hi_q;
    emit      = 1'b0;
    if (accept_i) begin
      case (state_q)
        ST_HUNT: begin
          if (rx_byte_i == marker_i) begin
            state_d = ST_CMD;
            sum_d   = '0;
          end
        end
        ST_CMD: begin
          command_d = dec;
          sum_d     = sum_q + SumW'(dec);
          state_d   = ST_PL0;
        end
        ST_PL0: begin
          payload_d[7:0] = dec;
          sum_d          = sum_q + SumW'(dec);
          state_d        = ST_PL1;
        end
        ST_PL1: begin
          payload_d[15:8] = dec;
          sum_d           = sum_q + SumW'(dec);
          state_d         = ST_PL2;
        end
        ST_PL2: begin
          payload_d[23:16] = dec;
          sum_d            = sum_q + SumW'(dec);
          state_d          = ST_PL3;
        end
        ST_PL3: begin
          payload_d[31:24] = dec;
          sum_d            = sum_q + SumW'(dec);
          state_d          = ST_CHK_HI;
        end
        ST_CHK_HI: begin
          chk_hi_d = dec;
          state_d  = ST_CHK_LO;
        end
        ST_CHK_LO: begin
          emit    = (check == CheckW'(sum_q));
          state_d = ST_HUNT;
        end
        default: begin
          state_d = ST_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  // Frame holds carry no reset; every field is written before use
  always_ff @(posedge clk_i) begin
    command_q <= command_d;
    payload_q <= payload_d;
    sum_q     <= sum_d;
    chk_hi_q  <= chk_hi_d;
  end

  assign result_o.command = command_q;
  assign result_o.payload = payload_q;
  assign status_o.state   = state_q;
  assign status_o.emit    = emit;

endmodule

### sv/ofd_out_buf.sv
// Result register with one skid entry for the offset frame deframer.
// Decouples output stalls from byte intake. Depends on ofd_pkg.

module ofd_out_buf
  import ofd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  frame_result_t push_data_i,
  output logic          ready_o,
  output logic          valid_o,
  input  logic          pop_ready_i,
  output frame_result_t data_o,
  output logic          skid_valid_o
);

  logic          main_valid_d, main_valid_q;
  logic          skid_valid_d, skid_valid_q;
  frame_result_t main_d, main_q;
  frame_result_t skid_d, skid_q;
  logic          pop;

  assign pop     = main_valid_q && pop_ready_i;
  assign ready_o = !skid_valid_q;

  // Load main from input or skid, park in skid when main stalls
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (push_i) begin
      if (!main_valid_q || pop) begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign valid_o      = main_valid_q;
  assign data_o       = main_q;
  assign skid_valid_o = skid_valid_q;

endmodule

### sv/offset_frame_deframer_core.sv
// Offset frame deframer, top level: register port, frame collector, result buffer.
// A result is registered from its last byte into the result register, or into the skid entry while that one waits.
// Throughput: one byte per cycle; intake pauses only while both result slots wait.
// Reset (rst_ni low, asynchronous): hunting, buffer empty, start marker 0x24.
// Depends on ofd_pkg, ofd_cfg, ofd_collect, ofd_out_buf.

module offset_frame_deframer_core
  import ofd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Byte input
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [ByteW-1:0]     s_axis_tdata,   // [7:0] rx_byte
  // Frame results
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TdataOutW-1:0] m_axis_tdata,   // [7:0] command, [39:8] payload
  // Register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrW-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic            accept;
  logic [ByteW-1:0] marker;
  frame_result_t   result;
  frame_result_t   out_data;
  collect_status_t status;
  logic            skid_valid;

  assign accept = s_axis_tvalid && s_axis_tready;

  ofd_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .marker_o (marker)
  );

  ofd_collect u_collect (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (s_axis_tdata),
    .marker_i  (marker),
    .result_o  (result),
    .status_o  (status)
  );

  ofd_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (status.emit),
    .push_data_i  (result),
    .ready_o      (s_axis_tready),
    .valid_o      (m_axis_tvalid),
    .pop_ready_i  (m_axis_tready),
    .data_o       (out_data),
    .skid_valid_o (skid_valid)
  );

  assign m_axis_tdata = {out_data.payload, out_data.command};

  // Skid entry is only ever filled behind a waiting main entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid |-> m_axis_tvalid)
    else $error("skid entry holds data while result register is empty");

  // Intake stalls only while a result is offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("byte intake stalled with no pending result");

  // A result is only produced on the low checksum byte of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.emit |-> (accept && status.state == ST_CHK_LO))
    else $error("result strobe outside the last frame byte");

  // After the last frame byte the collector hunts again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status.state == ST_CHK_LO) |=> (status.state == ST_HUNT))
    else $error("collector did not return to hunting after a frame");

endmodule
